>>> hw/rtl/gbts_pkg.sv
package gbts_pkg;

  localparam int unsigned CAPACITY = 4096;

  localparam int unsigned TYPE_W  = 2;
  localparam int unsigned POS_W   = 13;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [TYPE_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2
  } req_type_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_COPY_RD,
    S_COPY_WR,
    S_READ,
    S_READ_CAP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] insert_byte;
    logic [POS_W-1:0]  delete_count;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] read_byte;
    logic [POS_W-1:0]  text_length;
  } rsp_t;

endpackage

>>> hw/rtl/gbts_ram.sv
module gbts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/gap_buffer_text_store.sv
// Gap buffer text store. The text lives in one RAM of Capacity bytes around
// a free run (the gap). Each item is an insert of one byte, a delete of a
// run, or a read of one byte by logical index, and yields exactly one result
// with a status, the read byte and the text length after the item. Insert and
// delete first walk the gap to the requested position by copying one byte at a
// time through the single RAM port pair, each byte taking a compare, a read and
// then a write. One item is in flight at a time: in_stall_o is high from
// acceptance until the result is loaded into the output register. A finished
// result waits there while the next item is taken. The text RAM needs no
// clearing after reset.
module gap_buffer_text_store #(
  parameter int unsigned Capacity = gbts_pkg::CAPACITY
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  gbts_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output gbts_pkg::rsp_t out_rsp_o
);
  import gbts_pkg::*;

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned LW = $clog2(Capacity + 1);
  localparam int unsigned CW = ((LW > POS_W) ? LW : POS_W) + 1;

  state_e            state_q, state_d;
  logic [TYPE_W-1:0] op_q, op_d;
  logic [LW-1:0]     pos_q, pos_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [LW-1:0]     cnt_q, cnt_d;
  logic              fwd_q, fwd_d;
  logic [LW-1:0]     gb_q, gb_d;
  logic [LW-1:0]     gl_q, gl_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [BYTE_W-1:0] rd_q, rd_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;

  logic [LW-1:0]     len;
  logic [CW-1:0]     len_c, pos_c, cnt_c;
  logic [LW-1:0]     src_addr, dst_addr, read_addr;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  gbts_ram #(
    .Width (BYTE_W),
    .Depth (Capacity)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Text length and widened operands for the range checks.
  assign len   = LW'(Capacity) - gl_q;
  assign len_c = CW'(len);
  assign pos_c = CW'(in_req_i.position);
  assign cnt_c = CW'(in_req_i.delete_count);

  // Forward walk: take the byte just past the gap, drop it at the gap start.
  // Backward walk: take the byte just before the gap, drop it at the gap end.
  assign src_addr  = fwd_q ? (gb_q + gl_q) : (gb_q - LW'(1));
  assign dst_addr  = fwd_q ? gb_q : (gb_q + gl_q - LW'(1));
  // Map a logical index around the gap.
  assign read_addr = (pos_q < gb_q) ? pos_q : (pos_q + gl_q);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    pos_d       = pos_q;
    byte_d      = byte_q;
    cnt_d       = cnt_q;
    fwd_d       = fwd_q;
    gb_d        = gb_q;
    gl_d        = gl_q;
    status_d    = status_q;
    rd_d        = rd_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = dst_addr[AW-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = src_addr[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = in_req_i.req_type;
          pos_d    = LW'(in_req_i.position);
          byte_d   = in_req_i.insert_byte;
          cnt_d    = LW'(in_req_i.delete_count);
          rd_d     = '0;
          status_d = STAT_OK;
          state_d  = S_DONE;
          case (in_req_i.req_type)
            REQ_INSERT: begin
              // Position check comes before the full check.
              if (pos_c > len_c) begin
                status_d = STAT_RANGE;
              end else if (gl_q == '0) begin
                status_d = STAT_FULL;
              end else begin
                state_d = S_MOVE;
              end
            end
            REQ_DELETE: begin
              if ((pos_c > len_c) || (cnt_c > (len_c - pos_c))) begin
                status_d = STAT_RANGE;
              end else begin
                state_d = S_MOVE;
              end
            end
            REQ_READ: begin
              if (pos_c >= len_c) begin
                status_d = STAT_RANGE;
              end else begin
                state_d = S_READ;
              end
            end
            default: begin
              status_d = STAT_RANGE;
            end
          endcase
        end
      end

      S_MOVE: begin
        if (pos_q == gb_q) begin
          // Gap in place: fill one byte or widen over the deleted run.
          if (op_q == REQ_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = gb_q[AW-1:0];
            ram_wdata = byte_q;
            gb_d      = gb_q + LW'(1);
            gl_d      = gl_q - LW'(1);
          end else begin
            gl_d = gl_q + cnt_q;
          end
          state_d = S_DONE;
        end else begin
          fwd_d   = (pos_q > gb_q);
          state_d = S_COPY_RD;
        end
      end

      S_COPY_RD: begin
        ram_re  = 1'b1;
        state_d = S_COPY_WR;
      end

      S_COPY_WR: begin
        ram_we  = 1'b1;
        gb_d    = fwd_q ? (gb_q + LW'(1)) : (gb_q - LW'(1));
        state_d = S_MOVE;
      end

      S_READ: begin
        ram_re    = 1'b1;
        ram_raddr = read_addr[AW-1:0];
        state_d   = S_READ_CAP;
      end

      S_READ_CAP: begin
        rd_d    = ram_rdata;
        state_d = S_DONE;
      end

      S_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_d.status      = status_q;
          out_d.read_byte   = rd_q;
          out_d.text_length = POS_W'(len);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gb_q        <= '0;
      gl_q        <= LW'(Capacity);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gb_q        <= gb_d;
      gl_q        <= gl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    pos_q    <= pos_d;
    byte_q   <= byte_d;
    cnt_q    <= cnt_d;
    fwd_q    <= fwd_d;
    status_q <= status_d;
    rd_q     <= rd_d;
    out_q    <= out_d;
  end

endmodule
